// ===== hdl/lirs_pkg.sv =====
// Shared constants for the linear interpolation resampler.
// No dependencies; every other file of the block refers to it by scoped names.
package lirs_pkg;

  // Field widths that the parameters do not reach.
  localparam int unsigned STEP_W = 24;
  localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;

  // Defaults for the top level parameters.
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Most results that one input beat may cause.
  localparam int unsigned MAX_OUT = 64;

  // Input commands.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

endpackage

// ===== hdl/lirs_in_if.sv =====
// Input channel of the resampler: valid/ready handshake with command and sample.
// Depends on lirs_pkg for the default sample width.
interface lirs_in_if #(
  parameter int unsigned SAMPLE_WIDTH = lirs_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;

  modport source (output valid, output command, output in_sample, input ready);
  modport sink (input valid, input command, input in_sample, output ready);
endinterface

// ===== hdl/lirs_out_if.sv =====
// Output channel of the resampler: valid/ready handshake with sample and last flag.
// Depends on lirs_pkg for the default sample width.
interface lirs_out_if #(
  parameter int unsigned SAMPLE_WIDTH = lirs_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;
  logic                           last;

  modport source (output valid, output out_sample, output last, input ready);
  modport sink (input valid, input out_sample, input last, output ready);
endinterface

// ===== hdl/lirs_cfg_if.sv =====
// Configuration write channel of the resampler, carrying the phase step.
// Depends on lirs_pkg for the step width.
interface lirs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lirs_pkg::STEP_W-1:0]   phase_step;

  modport source (output valid, output phase_step, input ready);
  modport sink (input valid, input phase_step, output ready);
endinterface

// ===== hdl/lirs_mul.sv =====
// Shared multiplier of the resampler: signed difference times unsigned fraction,
// with a registered product. Depends on lirs_pkg for parameter defaults.
module lirs_mul #(
  parameter int unsigned SAMPLE_WIDTH = lirs_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS    = lirs_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [SAMPLE_WIDTH:0]          diff_i,
  input  logic        [FRAC_BITS-1:0]           frac_i,
  output logic signed [SAMPLE_WIDTH+FRAC_BITS+1:0] prod_o
);

  logic signed [FRAC_BITS:0]                 frac_s;
  logic signed [SAMPLE_WIDTH+FRAC_BITS+1:0]  prod_d;
  logic signed [SAMPLE_WIDTH+FRAC_BITS+1:0]  prod_q;

  assign frac_s = $signed({1'b0, frac_i});
  assign prod_d = (SAMPLE_WIDTH+FRAC_BITS+2)'(diff_i * frac_s);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hdl/linear_interp_resampler_unit.sv =====
// Top level of the linear interpolation sample rate converter.
// Depends on lirs_pkg, the three channel interfaces and lirs_mul.
//
// Usage: each input beat carries a command and a signed sample. A clear command
// empties the history and the phase; a sample beat after a clear or reset is only
// stored. Every later sample beat yields one result for each output point whose
// phase lies below one input interval, at most 64, the final one flagged by last.
// The configuration channel writes the phase step (unsigned Q8.16, input rate
// over output rate); it is always ready. The user must write it only while the
// block idles; the block itself does not enforce this. A beat that gives no
// results is taken in the idle state. Each result passes the multiplier state,
// where the shared multiplier registers its product, and then the add state,
// which adds the offset and loads the output register.
// The input is ready only while the sequencer idles, also while a finished
// result still waits in the output register. When the receiver stalls, the
// sequencer holds the next result until the output register is free.
// Reset clears the history, the phase, the output valid and sets the step to one.
module linear_interp_resampler_unit #(
  parameter int unsigned SAMPLE_WIDTH = lirs_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS    = lirs_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lirs_in_if.sink     in_i,
  lirs_out_if.source  out_o,
  lirs_cfg_if.sink    cfg_i
);

  localparam int unsigned StepW  = lirs_pkg::STEP_W;
  localparam int unsigned PhaseW = ((StepW > FRAC_BITS) ? StepW : FRAC_BITS) + 1;
  localparam int unsigned CntW   = $clog2(lirs_pkg::MAX_OUT);
  localparam int unsigned ProdW  = SAMPLE_WIDTH + FRAC_BITS + 2;
  localparam logic [PhaseW-1:0] PhaseOne = PhaseW'(1) << FRAC_BITS;
  localparam logic [CntW-1:0]   CntLast  = CntW'(lirs_pkg::MAX_OUT - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_ADD  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [StepW-1:0]               step_q, step_d;
  logic [SAMPLE_WIDTH-1:0]        prev_q, prev_d;
  logic [SAMPLE_WIDTH-1:0]        cur_q, cur_d;
  logic                           have_q, have_d;
  logic [PhaseW-1:0]              phase_q, phase_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic                           out_vld_q, out_vld_d;
  logic [SAMPLE_WIDTH-1:0]        out_smp_q, out_smp_d;
  logic                           out_last_q, out_last_d;

  logic                           in_beat;
  logic                           out_free;
  logic                           mul_en;
  logic signed [SAMPLE_WIDTH:0]   diff;
  logic signed [ProdW-1:0]        prod;
  logic signed [ProdW-1:0]        prod_sh;
  logic [SAMPLE_WIDTH+1:0]        y_wide;
  logic [PhaseW-1:0]              phase_sum;
  logic                           sum_ge_one;
  logic                           done;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_beat     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_vld_q || out_o.ready;

  assign diff   = $signed({cur_q[SAMPLE_WIDTH-1], cur_q} - {prev_q[SAMPLE_WIDTH-1], prev_q});
  assign mul_en = (state_q == ST_MUL);

  lirs_mul #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .diff_i (diff),
    .frac_i (phase_q[FRAC_BITS-1:0]),
    .prod_o (prod)
  );

  // The arithmetic shift rounds the product toward minus infinity.
  assign prod_sh    = prod >>> FRAC_BITS;
  assign y_wide     = {{2{prev_q[SAMPLE_WIDTH-1]}}, prev_q} + prod_sh[SAMPLE_WIDTH+1:0];
  assign phase_sum  = phase_q + {{(PhaseW-StepW){1'b0}}, step_q};
  assign sum_ge_one = (phase_sum >= PhaseOne);
  assign done       = sum_ge_one || (cnt_q == CntLast);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    have_d     = have_q;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    out_vld_d  = out_vld_q;
    out_smp_d  = out_smp_q;
    out_last_d = out_last_q;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (cfg_i.valid) begin
      step_d = cfg_i.phase_step;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          if (in_i.command == lirs_pkg::CMD_CLEAR) begin
            prev_d  = '0;
            have_d  = 1'b0;
            phase_d = '0;
          end else if (!have_q) begin
            prev_d  = in_i.in_sample;
            have_d  = 1'b1;
            phase_d = '0;
          end else if (phase_q >= PhaseOne) begin
            // No output point in this interval; only move the phase back.
            prev_d  = in_i.in_sample;
            phase_d = phase_q - PhaseOne;
          end else begin
            cur_d   = in_i.in_sample;
            cnt_d   = '0;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_smp_d  = y_wide[SAMPLE_WIDTH-1:0];
          out_last_d = done;
          cnt_d      = cnt_q + CntW'(1);
          if (done) begin
            // At the result cap the remaining points are dropped.
            phase_d = sum_ge_one ? (phase_sum - PhaseOne) : '0;
            prev_d  = cur_q;
            state_d = ST_IDLE;
          end else begin
            phase_d = phase_sum;
            state_d = ST_MUL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= lirs_pkg::STEP_RESET;
      prev_q    <= '0;
      have_q    <= 1'b0;
      phase_q   <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      prev_q    <= prev_d;
      have_q    <= have_d;
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_smp_q  <= out_smp_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.out_sample = out_smp_q;
  assign out_o.last       = out_last_q;

endmodule

// ===== dv/linear_interp_resampler_unit_test.sv =====
// Self-checking testbench for linear_interp_resampler_unit: drives sample and clear beats,
// rewrites the phase step between phases and checks every interpolated output in order.
// Depends on lirs_pkg, the three channel interfaces and the resampler RTL.
module linear_interp_resampler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SW = lirs_pkg::SAMPLE_WIDTH_DEF;
  localparam int unsigned FB = lirs_pkg::FRAC_BITS_DEF;
  localparam int unsigned STW = lirs_pkg::STEP_W;
  localparam logic [24:0] PHASE_ONE = 25'(1) << FB;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 32;

  typedef logic signed [SW-1:0] sample_t;
  typedef logic [STW-1:0] step_t;

  typedef struct packed {
    sample_t value;
    logic    last;
  } interp_point_t;

  // Keeps its own copy of the resampler state and the queue of pending output points.
  class resample_board;
    step_t           step;
    sample_t         prev;
    logic            have_prev;
    logic [24:0]     phase;
    interp_point_t   points_q[$];
    int unsigned     mismatches;
    int unsigned     results_seen;

    function new();
      step = lirs_pkg::STEP_RESET;
      prev = '0;
      have_prev = 1'b0;
      phase = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_step(step_t v);
      step = v;
    endfunction

    function int pending();
      return points_q.size();
    endfunction

    function void note_input(logic cmd, sample_t cur);
      longint        diff;
      longint        prod;
      longint        y;
      logic [24:0]   next_phase;
      int            n;
      interp_point_t pt;
      if (cmd == lirs_pkg::CMD_CLEAR) begin
        prev = '0;
        have_prev = 1'b0;
        phase = '0;
        return;
      end
      if (!have_prev) begin
        prev = cur;
        have_prev = 1'b1;
        phase = '0;
        return;
      end
      n = 0;
      while (phase < PHASE_ONE && n < int'(lirs_pkg::MAX_OUT)) begin
        diff = longint'(cur) - longint'(prev);
        prod = diff * longint'(phase);
        // Arithmetic shift rounds the product toward minus infinity.
        y = longint'(prev) + (prod >>> FB);
        next_phase = phase + 25'(step);
        n++;
        pt.value = y[SW-1:0];
        pt.last = !(next_phase < PHASE_ONE && n < int'(lirs_pkg::MAX_OUT));
        points_q.insert(points_q.size(), pt);
        phase = next_phase;
      end
      if (phase >= PHASE_ONE) begin
        phase = phase - PHASE_ONE;
      end else begin
        phase = '0;
      end
      prev = cur;
    endfunction

    function void check_result(sample_t value, logic last);
      interp_point_t want;
      results_seen++;
      if (points_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected output: out_sample=%0d last=%0b", value, last);
        end
        return;
      end
      want = points_q.pop_front();
      if (want.value !== value || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("output mismatch: expected out_sample=%0d last=%0b, %s",
                   want.value, want.last,
                   $sformatf("got out_sample=%0d last=%0b", value, last));
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lirs_in_if  in_if();
  lirs_out_if out_if();
  lirs_cfg_if cfg_if();

  linear_interp_resampler_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  resample_board board;
  int unsigned   cycle_count;
  logic          tx_fast;
  logic          hold_armed;
  logic          hold_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("linear_interp_resampler_unit_test NOT OK");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      board.check_result(out_if.out_sample, out_if.last);
    end
  end

  // Output side: random stalls, calm stretches, and one long hold-off that backs up the block.
  initial begin
    int unsigned stall;
    int unsigned taken;
    logic        rx_fast;
    out_if.ready <= 1'b0;
    taken = 0;
    rx_fast = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 48 == 0) begin
        rx_fast = ($urandom_range(0, 2) == 0);
      end
      stall = rx_fast ? 0 : $urandom_range(0, 19);
      if (hold_armed && !hold_done) begin
        stall = 400;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      taken++;
    end
  end

  task automatic send_beat(input logic cmd, input sample_t value);
    int unsigned gap;
    gap = tx_fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.command <= cmd;
    in_if.in_sample <= value;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_input(cmd, value);
  endtask

  task automatic send_sample(input sample_t value);
    send_beat(lirs_pkg::CMD_SAMPLE, value);
  endtask

  // Stops offering beats and waits until every pending output point has come out.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_step(input step_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.phase_step <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    board.set_step(v);
  endtask

  function automatic sample_t pick_sample();
    logic [SW-1:0] raw;
    raw = SW'($urandom);
    case ($urandom_range(0, 7))
      0: pick_sample = {1'b0, {(SW-1){1'b1}}};
      1: pick_sample = {1'b1, {(SW-1){1'b0}}};
      2: pick_sample = sample_t'($signed($urandom_range(0, 15)) - 8);
      default: pick_sample = raw;
    endcase
  endfunction

  function automatic step_t pick_step();
    case ($urandom_range(0, 5))
      0: pick_step = step_t'($urandom_range(1024, 4096));
      1: pick_step = step_t'($urandom_range(1024, 24'hFFFFFF));
      2: pick_step = step_t'(65536);
      default: pick_step = step_t'($urandom_range(16384, 262144));
    endcase
  endfunction

  initial begin
    logic cmd;
    board = new();
    tx_fast = 1'b0;
    hold_armed = 1'b0;
    hold_done = 1'b0;
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.command <= lirs_pkg::CMD_SAMPLE;
    in_if.in_sample <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.phase_step <= lirs_pkg::STEP_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Unit step: one output per interval, equal to the previous sample.
    write_step(step_t'(65536));
    send_sample(sample_t'(100));
    send_sample({1'b0, {(SW-1){1'b1}}});
    send_sample({1'b1, {(SW-1){1'b0}}});
    send_sample(sample_t'(0));
    send_sample(sample_t'(-1));
    send_beat(lirs_pkg::CMD_CLEAR, sample_t'(-1));
    send_beat(lirs_pkg::CMD_CLEAR, sample_t'(12345));
    send_sample(sample_t'(5));
    send_sample(sample_t'(7));
    drain();

    // Half step: a falling interval exercises rounding toward minus infinity.
    write_step(step_t'(32768));
    send_sample(sample_t'(-8));
    send_sample({1'b0, {(SW-1){1'b1}}});
    send_sample({1'b1, {(SW-1){1'b0}}});
    send_sample(sample_t'(3));
    drain();

    // Smallest step: every interval produces the full 64 outputs.
    write_step(step_t'(1024));
    send_sample(sample_t'(1000));
    send_sample(sample_t'(-1000));
    drain();

    // Largest step: the phase overshoots, so following intervals give nothing.
    tx_fast = 1'b1;
    write_step(step_t'(24'hFFFFFF));
    send_sample(sample_t'(1));
    send_sample(sample_t'(2));
    send_sample(sample_t'(3));
    send_beat(lirs_pkg::CMD_CLEAR, '0);
    send_sample(sample_t'(4));
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_step(pick_step());
      tx_fast = ($urandom_range(0, 3) == 0);
      if (p == 1) begin
        hold_armed = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        cmd = ($urandom_range(0, 29) == 0) ? lirs_pkg::CMD_CLEAR : lirs_pkg::CMD_SAMPLE;
        send_beat(cmd, pick_sample());
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("linear_interp_resampler_unit_test OK");
    end else begin
      $display("linear_interp_resampler_unit_test NOT OK");
    end
    $finish;
  end

endmodule
